// File: hdl/hp2r_pkg.sv
// shared types, constants and the srgb threshold table for the half to rgba8 converter
package hp2r_pkg;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CH_NUM = 4;
  localparam int unsigned MAG_W  = HALF_W - 1;
  localparam int unsigned FIX_W  = 25;

  // magnitude bits of +1.0 and the all-ones exponent code
  localparam logic [MAG_W-1:0] HALF_ONE_MAG = 15'h3C00;
  localparam logic [4:0]       EXP_SPECIAL  = 5'd31;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [255:0][MAG_W-1:0] srgb_thr_t;
  typedef logic [319:0] wide_t;

  // per channel control into the converter
  typedef struct packed {
    logic srgb_en;
  } chan_ctrl_t;

  // exact value of a non-negative half below 2.0 as an integer scaled by 2^24
  function automatic logic [FIX_W-1:0] half_mag_to_fixed(input logic [MAG_W-1:0] mag);
    logic [4:0]       e;
    logic [9:0]       f;
    logic [FIX_W-1:0] v;
    e = mag[14:10];
    f = mag[9:0];
    if (e == 5'd0) begin
      v = {15'd0, f};
    end else begin
      v = {14'd0, 1'b1, f} << (e - 5'd1);
    end
    return v;
  endfunction

  // true when the encoded value of mag rounds to k or above
  function automatic logic srgb_reaches(input logic [MAG_W-1:0] mag, input logic [8:0] k,
                                        input wide_t c12, input wide_t rhs);
    logic [FIX_W-1:0] v;
    logic [63:0]      v64;
    wide_t            lhs;
    wide_t            vw;
    v   = half_mag_to_fixed(mag);
    v64 = {39'd0, v};
    vw  = {295'd0, v};
    if (v64 * 64'd10000000 <= (64'd31308 << 24)) begin
      return (v64 * 64'd32946 + (64'd5 << 24)) >= ({55'd0, k} * (64'd10 << 24));
    end
    lhs = vw * vw;
    lhs = lhs * vw;
    lhs = lhs * vw;
    lhs = lhs * vw;
    lhs = lhs * c12;
    return lhs >= rhs;
  endfunction

  // smallest half magnitude that reaches each output code, built at elaboration
  function automatic srgb_thr_t build_srgb_thr();
    srgb_thr_t   tab;
    wide_t       c12;
    wide_t       rhs;
    wide_t       base;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] mid;
    tab = '0;
    c12 = wide_t'(1);
    for (int i = 0; i < 12; i++) begin
      c12 = c12 * wide_t'(10761);
    end
    for (int k = 1; k < 256; k++) begin
      base = wide_t'(40 * k + 541);
      rhs  = wide_t'(1);
      for (int i = 0; i < 12; i++) begin
        rhs = rhs * base;
      end
      rhs = rhs << 120;
      lo  = 16'd0;
      hi  = {1'b0, HALF_ONE_MAG};
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (srgb_reaches(mid[MAG_W-1:0], 9'(k), c12, rhs)) begin
          hi = mid;
        end else begin
          lo = mid + 16'd1;
        end
      end
      tab[k] = lo[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam srgb_thr_t SRGB_THR = build_srgb_thr();

endpackage

// File: hdl/half_pixel_to_rgba8_capture.sv
// top level: rgba half pixel to rgba8 with optional srgb encode of the color channels
//
//  channel   dir  handshake                     payload (low bits first)
//  s_axis    in   s_axis_tvalid/s_axis_tready   red, green, blue, alpha halves
//  m_axis    out  m_axis_tvalid/m_axis_tready   red, green, blue, alpha bytes
//  cfg       in   cfg_we_i                      encode_color_srgb in cfg_wdata_i
//
// one pixel accepted per clock while the output is not stalled, set by the input register
// feeding the output register through one pass of the channel converters
// a pixel passes the input register, then the output register, before its output request
// reset clears both valid flags and sets srgb encode on
// a stalled output holds its request; the input register still takes one more
// pixel, and ready follows m_axis_tready once both registers hold data
module half_pixel_to_rgba8_capture
  import hp2r_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // red [15:0], green [31:16], blue [47:32], alpha [63:48]
  input  logic [CH_NUM*HALF_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  output logic [CH_NUM*BYTE_W-1:0] m_axis_tdata
);

  // encode register
  logic srgb_en_q, srgb_en_d;

  // input stage
  logic                     in_valid_q, in_valid_d;
  logic [CH_NUM*HALF_W-1:0] in_data_q;

  // output stage
  logic                     out_valid_q, out_valid_d;
  logic [CH_NUM*BYTE_W-1:0] out_data_q, out_data_d;

  logic s_accept;
  logic in_adv;

  // input moves on when the output register is free or being drained
  assign in_adv        = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || in_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign srgb_en_d = cfg_we_i ? cfg_wdata_i : srgb_en_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (in_adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // converters, alpha never srgb encoded
  for (genvar c = 0; c < CH_NUM; c++) begin : g_chan
    chan_ctrl_t ctrl;
    assign ctrl.srgb_en = (c < CH_NUM - 1) ? srgb_en_q : 1'b0;

    hp2r_chan_conv u_conv (
      .half_i (in_data_q[c*HALF_W +: HALF_W]),
      .ctrl_i (ctrl),
      .byte_o (out_data_d[c*BYTE_W +: BYTE_W])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srgb_en_q   <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      srgb_en_q   <= srgb_en_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata;
    end
    if (in_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: hdl/hp2r_chan_conv.sv
// one channel: half clamp, then srgb threshold search or linear scale to 8 bits
module hp2r_chan_conv
  import hp2r_pkg::*;
(
  input  half_t      half_i,
  input  chan_ctrl_t ctrl_i,
  output byte_t      byte_o
);

  logic             sign;
  logic             is_nan;
  logic [MAG_W-1:0] mag;
  logic [FIX_W-1:0] fixed;
  logic [31:0]      lin_prod;
  byte_t            lin_byte;
  byte_t            srgb_byte;
  logic [255:0]     ge;

  assign sign   = half_i[15];
  assign mag    = half_i[MAG_W-1:0];
  assign is_nan = (mag[14:10] == EXP_SPECIAL) && (mag[9:0] != 10'd0);
  assign fixed  = half_mag_to_fixed(mag);

  // round half up, value below one here
  assign lin_prod = {7'd0, fixed} * 32'd255 + (32'd1 << 23);
  assign lin_byte = lin_prod[31:24];

  // thermometer of threshold hits
  always_comb begin
    for (int k = 0; k < 256; k++) begin
      ge[k] = (mag >= SRGB_THR[k]);
    end
  end

  // thermometer to code, one bit per level
  always_comb begin
    byte_t cand;
    srgb_byte = '0;
    for (int lvl = BYTE_W - 1; lvl >= 0; lvl--) begin
      cand = srgb_byte | (byte_t'(1) << lvl);
      if (ge[cand]) begin
        srgb_byte = cand;
      end
    end
  end

  always_comb begin
    if (sign || is_nan) begin
      byte_o = '0;
    end else if (mag >= HALF_ONE_MAG) begin
      byte_o = '1;
    end else if (ctrl_i.srgb_en) begin
      byte_o = srgb_byte;
    end else begin
      byte_o = lin_byte;
    end
  end

endmodule

// File: hdl/hp2r_checker.sv
// port level checks for the half to rgba8 converter, bound to the top level
module hp2r_checker
  import hp2r_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [CH_NUM*BYTE_W-1:0] m_axis_tdata
);

  // stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // result request cleared once reset has been seen at an edge
  a_rst_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result request during reset");

  // input side open whenever the output side drains
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked while output free");

  // full pipeline under stall stays closed
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> m_axis_tready || !s_axis_tready)
    else $error("input opened with a full stalled pipeline");

endmodule

bind half_pixel_to_rgba8_capture hp2r_checker u_hp2r_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_half_pixel_to_rgba8_capture.sv
// stream testbench for the rgba half pixel to rgba8 converter with srgb encode on and off
module tb_half_pixel_to_rgba8_capture;
  import hp2r_pkg::*;

  // channel order inside a pixel, red in the lowest bits
  typedef enum int {
    CH_RED   = 0,
    CH_GREEN = 1,
    CH_BLUE  = 2,
    CH_ALPHA = 3
  } chan_e;

  typedef half_t [CH_NUM-1:0] half_px_t;
  typedef byte_t [CH_NUM-1:0] rgba8_t;
  typedef logic [319:0]       big_t;

  // encode mode register values
  localparam bit MODE_LINEAR = 1'b0;
  localparam bit MODE_SRGB   = 1'b1;

  // interesting binary16 patterns
  localparam half_t HALF_POS_ZERO   = 16'h0000;
  localparam half_t HALF_NEG_ZERO   = 16'h8000;
  localparam half_t HALF_ONE        = 16'h3C00;
  localparam half_t HALF_ABOVE_ONE  = 16'h3C01;
  localparam half_t HALF_BELOW_ONE  = 16'h3BFF;
  localparam half_t HALF_POS_INF    = 16'h7C00;
  localparam half_t HALF_NEG_INF    = 16'hFC00;
  localparam half_t HALF_QNAN       = 16'h7E00;
  localparam half_t HALF_NEG_NAN    = 16'hFFFF;
  localparam half_t HALF_SNAN       = 16'h7C01;
  localparam half_t HALF_MIN_SUB    = 16'h0001;
  localparam half_t HALF_MAX_SUB    = 16'h03FF;
  localparam half_t HALF_MIN_NORM   = 16'h0400;
  localparam half_t HALF_MAX_FINITE = 16'h7BFF;
  localparam half_t HALF_KNEE_LO    = 16'h1A69;  // last value on the linear srgb segment
  localparam half_t HALF_KNEE_HI    = 16'h1A6A;  // first value on the power segment
  localparam half_t HALF_HALF       = 16'h3800;
  localparam half_t HALF_NEG_ONE    = 16'hBC00;

  localparam int          CORNER_NUM  = 18;
  localparam logic [63:0] FIX_ONE     = 64'd1 << 24;
  localparam int          DRAIN_WAIT  = 6;
  localparam int          CYCLE_LIMIT = 300000;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   cfg_we_i      = 1'b0;
  logic   cfg_wdata_i   = 1'b0;
  logic   s_axis_tvalid = 1'b0;
  logic   s_axis_tready;
  // red [15:0], green [31:16], blue [47:32], alpha [63:48]
  logic [CH_NUM*HALF_W-1:0] s_axis_tdata = '0;
  logic   m_axis_tvalid;
  logic   m_axis_tready = 1'b0;
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  logic [CH_NUM*BYTE_W-1:0] m_axis_tdata;

  // idle percentages of the two sides
  int send_idle_pct = 24;
  int recv_idle_pct = 87;

  // mirror of the encode register, reset value is srgb on
  bit srgb_mode = MODE_SRGB;

  // bytes still owed by the block, oldest first
  rgba8_t rgba8_pending_q [$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;

  // 10761^12 and the power segment thresholds (40k+541)^12 * 2^120 per code k
  big_t srgb_coef12;
  big_t srgb_rhs [256];

  string byte_names [CH_NUM] = '{"red_byte", "green_byte", "blue_byte", "alpha_byte"};

  half_t corner_halves [CORNER_NUM] = '{
    HALF_POS_ZERO, HALF_NEG_ZERO, HALF_ONE, HALF_ABOVE_ONE, HALF_BELOW_ONE, HALF_POS_INF,
    HALF_NEG_INF, HALF_QNAN, HALF_NEG_NAN, HALF_SNAN, HALF_MIN_SUB, HALF_MAX_SUB,
    HALF_MIN_NORM, HALF_MAX_FINITE, HALF_KNEE_LO, HALF_KNEE_HI, HALF_HALF, HALF_NEG_ONE
  };

  half_pixel_to_rgba8_capture uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one channel: clamp the half to [0,1] as an integer scaled by 2^24, then encode
  function automatic byte_t channel_byte(input half_t h, input bit srgb);
    logic [4:0]  expo;
    logic [9:0]  frac;
    logic [63:0] fix;
    big_t        lhs;
    int          lo;
    int          hi;
    int          mid;
    expo = h[14:10];
    frac = h[9:0];
    if (expo == 5'h1F) begin
      // nan goes to zero, only plus infinity saturates
      fix = (frac == 10'd0 && !h[15]) ? FIX_ONE : 64'd0;
    end else if (h[15]) begin
      fix = 64'd0;
    end else if (expo == 5'd0) begin
      fix = 64'(frac);
    end else begin
      fix = 64'({1'b1, frac}) << (expo - 5'd1);
    end
    if (fix > FIX_ONE) begin
      fix = FIX_ONE;
    end
    if (!srgb) begin
      return byte_t'((fix * 64'd255 + (FIX_ONE >> 1)) >> 24);
    end
    // linear toe of the srgb curve, 12.92 x
    if (fix * 64'd10000000 <= 64'd31308 * FIX_ONE) begin
      return byte_t'((fix * 64'd32946 + 64'd5 * FIX_ONE) / (64'd10 * FIX_ONE));
    end
    // power segment: largest code whose threshold the value reaches
    lhs = big_t'(fix);
    repeat (4) lhs = lhs * big_t'(fix);
    lhs = lhs * srgb_coef12;
    lo  = 0;
    hi  = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (lhs >= srgb_rhs[mid]) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return byte_t'(lo);
  endfunction

  function automatic rgba8_t predict_rgba8(input half_px_t px);
    rgba8_t res;
    for (int c = 0; c < CH_NUM; c++) begin
      res[c] = channel_byte(px[c], srgb_mode && (c != CH_ALPHA));
    end
    return res;
  endfunction

  // random half biased toward the range that is not clamped away
  function automatic half_t random_half();
    half_t h;
    case ($urandom_range(9))
      0, 1:    h = half_t'($urandom_range(16'hFFFF));
      2, 3, 4: h = half_t'($urandom_range(HALF_ONE));
      5:       h = half_t'($urandom_range(16'h1A90, 16'h1A40));
      6:       h = half_t'($urandom_range(HALF_MAX_SUB));
      7:       h = half_t'($urandom_range(16'h3C10, 16'h3B00));
      8:       h = {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023))};
      default: h = {1'b1, 15'($urandom_range(16'h7FFF))};
    endcase
    return h;
  endfunction

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    rgba8_t want;
    rgba8_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rgba8_t'(m_axis_tdata);
      if (rgba8_pending_q.size() == 0) begin
        $error("unexpected output pixel %h", m_axis_tdata);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = rgba8_pending_q.pop_front();
        for (int c = 0; c < CH_NUM; c++) begin
          if (got[c] !== want[c]) begin
            $error("%s mismatch: expected %0d, actual %0d", byte_names[c], want[c], got[c]);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
    end
  end

  // send one pixel request; called just after a rising edge, returns at the accepting edge
  // with valid still high so back to back requests need no second assignment in one step
  task automatic send_pixel(input half_px_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    rgba8_pending_q = {rgba8_pending_q, predict_rgba8(px)};
  endtask

  // stop sending and wait until every owed pixel is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (rgba8_pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_encode_mode(input bit mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    srgb_mode = mode;
  endtask

  // random pixels; at pause_at the sender holds off until the block is empty
  task automatic send_random_pixels(input int count, input int pause_at);
    half_px_t px;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        wait_drained();
      end
      for (int c = 0; c < CH_NUM; c++) begin
        px[c] = random_half();
      end
      send_pixel(px);
    end
  endtask

  // zeros, infinities, nans, subnormals, the srgb knee and values around one,
  // rotated so every pattern lands on every channel, alpha included
  task automatic test_directed_corners();
    half_px_t px;
    for (int i = 0; i < CORNER_NUM; i++) begin
      px[CH_RED]   = corner_halves[i];
      px[CH_GREEN] = corner_halves[(i + 5) % CORNER_NUM];
      px[CH_BLUE]  = corner_halves[(i + 11) % CORNER_NUM];
      px[CH_ALPHA] = corner_halves[(i + 3) % CORNER_NUM];
      send_pixel(px);
    end
  endtask

  // linear mode under heavy output stall, with a full drain in the middle
  task automatic test_linear_random();
    write_encode_mode(MODE_LINEAR);
    send_idle_pct = 24;
    recv_idle_pct = 87;
    send_random_pixels(500, 250);
  endtask

  // srgb mode with a slow sender
  task automatic test_srgb_random();
    write_encode_mode(MODE_SRGB);
    send_idle_pct = 87;
    recv_idle_pct = 24;
    send_random_pixels(500, -1);
  endtask

  // both modes at one pixel per clock
  task automatic test_full_rate();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pixels(275, -1);
    write_encode_mode(MODE_LINEAR);
    send_random_pixels(275, -1);
  endtask

  initial begin
    // threshold table for the power segment of the srgb curve
    srgb_coef12 = big_t'(1);
    for (int i = 0; i < 12; i++) begin
      srgb_coef12 = srgb_coef12 * big_t'(10761);
    end
    srgb_rhs[0] = '0;
    for (int k = 1; k < 256; k++) begin
      srgb_rhs[k] = big_t'(1);
      for (int i = 0; i < 12; i++) begin
        srgb_rhs[k] = srgb_rhs[k] * big_t'(40 * k + 541);
      end
      srgb_rhs[k] = srgb_rhs[k] << 120;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_linear_random();
    test_srgb_random();
    test_full_rate();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
